@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
// PRA_ASSERT is gated by reset; PRA_ASSERT_ALWAYS also checks during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PRA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRA_ASSERT(label, clk, rst, prop, msg)
`define PRA_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ design/pra_pkg.sv @@
`timescale 1ns / 1ps
package pra_pkg;

   // Field widths.
   localparam int COORD_W = 32;
   localparam int AXIS_W = 32;
   localparam int ANGLE_W = 26;
   localparam int VEC_W = COORD_W + 1;
   localparam int TRIG_W = 34;
   localparam int ZETA_W = 44;
   localparam int PROD_W = 40;
   localparam int SUM_W = 38;
   localparam int ROT_W = 42;
   localparam int FRAC_SHIFT = 30;
   localparam int CORDIC_STEPS = 24;

   // Half-angle handling in Q.17 degrees.
   localparam int HANG_W = ANGLE_W + 1;
   localparam int HMAG_W = 24;
   localparam logic signed [HANG_W-1:0] HALF_TURN = HANG_W'(180 << 17);
   localparam logic signed [HANG_W-1:0] FULL_TURN = HANG_W'(360 << 17);
   localparam logic signed [HANG_W-1:0] QUARTER_TURN = HANG_W'(90 << 17);

   // Degrees to radians, split into two narrow partial products.
   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic [63:0] DEG_TO_RAD_Q60 = PI_Q60 / 64'd180;
   localparam int KSPLIT = 28;
   localparam int K_HI_W = 28;
   localparam logic [KSPLIT-1:0] K_LO = DEG_TO_RAD_Q60[KSPLIT-1:0];
   localparam logic [K_HI_W-1:0] K_HI = DEG_TO_RAD_Q60[KSPLIT+K_HI_W-1:KSPLIT];
   localparam int RAD_W = HMAG_W + K_HI_W + KSPLIT;
   localparam int RAD_SHIFT = 37;

   // CORDIC start value, 1/gain in Q30.
   localparam logic signed [TRIG_W-1:0] CORDIC_X0 = TRIG_W'(32'h26DD3B6A);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ANGLE_W-1:0] angle_type;
   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [ZETA_W-1:0] zeta_type;
   typedef logic signed [PROD_W-1:0] prod_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [ROT_W-1:0] acc_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      coord_type point_z;
      coord_type offset_x;
      coord_type offset_y;
      coord_type offset_z;
      coord_type axis_x;
      coord_type axis_y;
      coord_type axis_z;
      angle_type turn_degrees;
   } req_beat_type;

   typedef struct packed {
      vec_type   v_x;
      vec_type   v_y;
      vec_type   v_z;
      coord_type o_x;
      coord_type o_y;
      coord_type o_z;
      coord_type a_x;
      coord_type a_y;
      coord_type a_z;
   } geom_type;

   typedef struct packed {
      logic     valid;
      logic     flip;
      zeta_type zeta;
      geom_type geom;
   } ang_stage_type;

   typedef struct packed {
      logic     valid;
      logic     flip;
      trig_type cos_v;
      trig_type sin_v;
      geom_type geom;
   } trig_stage_type;

   typedef struct packed {
      logic      valid;
      coord_type rotated_x;
      coord_type rotated_y;
      coord_type rotated_z;
   } rsp_beat_type;

   // Restoring division, used only on constants while building the arctangent table.
   function automatic logic [63:0] udiv_const(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Arctangent of 2^-step in Q40, from the truncated Taylor series in Q60.
   function automatic zeta_type atan_q40(input int step);
      logic signed [63:0] acc;
      logic [63:0] term;
      acc = '0;
      term = '0;
      if (step == 0) begin
         return ZETA_W'(PI_Q60 >> 22);
      end
      for (int k = 0; step * (2 * k + 1) <= 60; k++) begin
         term = udiv_const(64'd1 << (60 - step * (2 * k + 1)), 64'(2 * k + 1));
         if ((k & 1) != 0) begin
            acc = acc - signed'(term);
         end else begin
            acc = acc + signed'(term);
         end
      end
      return ZETA_W'(acc >>> 20);
   endfunction

   // Signed product scaled by 2^-30, magnitude truncated.
   function automatic prod_type mul_q30_narrow(input trig_type a, input trig_type b);
      logic [TRIG_W-1:0] ua;
      logic [TRIG_W-1:0] ub;
      logic [2*TRIG_W-1:0] full;
      logic [PROD_W-1:0] mag;
      ua = a[TRIG_W-1] ? (~a + 1'b1) : a;
      ub = b[TRIG_W-1] ? (~b + 1'b1) : b;
      full = ua * ub;
      mag = PROD_W'(full >> FRAC_SHIFT);
      return (a[TRIG_W-1] ^ b[TRIG_W-1]) ? prod_type'(~mag + 1'b1) : prod_type'(mag);
   endfunction

   // Same for a wide partial sum times a quaternion component.
   function automatic acc_type mul_q30_wide(input sum_type a, input trig_type b);
      logic [SUM_W-1:0] ua;
      logic [TRIG_W-1:0] ub;
      logic [SUM_W+TRIG_W-1:0] full;
      logic [ROT_W-1:0] mag;
      ua = a[SUM_W-1] ? (~a + 1'b1) : a;
      ub = b[TRIG_W-1] ? (~b + 1'b1) : b;
      full = ua * ub;
      mag = ROT_W'(full >> FRAC_SHIFT);
      return (a[SUM_W-1] ^ b[TRIG_W-1]) ? acc_type'(~mag + 1'b1) : acc_type'(mag);
   endfunction

endpackage

@@ design/pra_req_if.sv @@
`timescale 1ns / 1ps
interface pra_req_if;
   import pra_pkg::*;
   logic      valid;
   logic      ready;
   coord_type point_x;
   coord_type point_y;
   coord_type point_z;
   coord_type offset_x;
   coord_type offset_y;
   coord_type offset_z;
   coord_type axis_x;
   coord_type axis_y;
   coord_type axis_z;
   angle_type turn_degrees;

   modport source (
      output valid, point_x, point_y, point_z, offset_x, offset_y, offset_z,
      output axis_x, axis_y, axis_z, turn_degrees,
      input  ready
   );
   modport sink (
      input  valid, point_x, point_y, point_z, offset_x, offset_y, offset_z,
      input  axis_x, axis_y, axis_z, turn_degrees,
      output ready
   );
endinterface

@@ design/pra_rsp_if.sv @@
`timescale 1ns / 1ps
interface pra_rsp_if;
   import pra_pkg::*;
   logic      valid;
   logic      ready;
   coord_type rotated_x;
   coord_type rotated_y;
   coord_type rotated_z;

   modport source (output valid, rotated_x, rotated_y, rotated_z, input ready);
   modport sink (input valid, rotated_x, rotated_y, rotated_z, output ready);
endinterface

@@ design/point_rotate_about_axis.sv @@
`timescale 1ns / 1ps
// Rotates a 3-D point about an axis through an offset point by a quaternion.
// Input channel req_chan carries one point, offset, axis direction and angle
// per beat; result channel rsp_chan carries the rotated coordinates.
// Both channels use valid/ready; a beat moves when both are high.
// An accepted input beat passes angle preparation, 24 CORDIC micro-rotation
// stages and 5 stages of quaternion products, sums and saturation before
// its result beat appears.
// Throughput is one beat per cycle while no shown result is stalled; each
// CORDIC step and each product layer has its own register stage.
// Reset clears every stage valid bit; the pipeline is empty afterwards and
// ready is high.
// When the receiver holds rsp_chan.ready low while a result is shown, the
// whole pipeline freezes, req_chan.ready drops, and nothing is lost or
// repeated; it moves again in the cycle ready returns.
`include "assert_macros.svh"
module point_rotate_about_axis (
   input logic       clock,
   input logic       reset,
   pra_req_if.sink   req_chan,
   pra_rsp_if.source rsp_chan
);
   import pra_pkg::*;

   logic           enable;
   req_beat_type   in_beat;
   ang_stage_type  ang_out;
   trig_stage_type cordic_out;
   rsp_beat_type   out_beat;

   // Global advance: the pipeline moves unless a shown result is stalled.
   assign enable         = !out_beat.valid || rsp_chan.ready;
   assign req_chan.ready = enable;

   assign in_beat.point_x      = req_chan.point_x;
   assign in_beat.point_y      = req_chan.point_y;
   assign in_beat.point_z      = req_chan.point_z;
   assign in_beat.offset_x     = req_chan.offset_x;
   assign in_beat.offset_y     = req_chan.offset_y;
   assign in_beat.offset_z     = req_chan.offset_z;
   assign in_beat.axis_x       = req_chan.axis_x;
   assign in_beat.axis_y       = req_chan.axis_y;
   assign in_beat.axis_z       = req_chan.axis_z;
   assign in_beat.turn_degrees = req_chan.turn_degrees;

   pra_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_chan.valid),
      .in_beat   (in_beat),
      .out_stage (ang_out)
   );

   pra_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_stage  (ang_out),
      .out_stage (cordic_out)
   );

   pra_quat u_quat (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_stage (cordic_out),
      .out_beat (out_beat)
   );

   assign rsp_chan.valid     = out_beat.valid;
   assign rsp_chan.rotated_x = out_beat.rotated_x;
   assign rsp_chan.rotated_y = out_beat.rotated_y;
   assign rsp_chan.rotated_z = out_beat.rotated_z;

   // Reset leaves the pipeline empty.
   `PRA_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_chan.valid, "result after reset")
   // A stalled result freezes the inner stages too.
   `PRA_ASSERT(a_stall_freezes, clock, reset, rsp_chan.valid && !rsp_chan.ready |=> $stable(ang_out.valid) && $stable(cordic_out.valid), "pipeline moved in stall")
   // An accepted beat passes the angle stages to the CORDIC input while the pipeline advances.
   `PRA_ASSERT(a_angle_latency, clock, reset, req_chan.valid && req_chan.ready ##1 enable ##1 enable ##1 enable |=> ang_out.valid, "beat lost in angle stages")
endmodule

@@ design/pra_angle.sv @@
`timescale 1ns / 1ps
module pra_angle (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  pra_pkg::req_beat_type in_beat,
   output pra_pkg::ang_stage_type out_stage
);
   import pra_pkg::*;

   logic                      valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic signed [HANG_W-1:0]  h1_ff, h1_in, h0;
   geom_type                  geom1_ff, geom1_in, geom2_ff, geom3_ff, geom4_ff;
   logic signed [HANG_W-1:0]  hf;
   logic                      flip2_ff, flip2_in, flip3_ff, flip4_ff;
   logic                      neg2_ff, neg2_in, neg3_ff;
   logic [HMAG_W-1:0]         mag2_ff, mag2_in;
   logic [HMAG_W+K_HI_W-1:0]  phi3_ff, phi3_in;
   logic [HMAG_W+KSPLIT-1:0]  plo3_ff, plo3_in;
   logic [RAD_W-1:0]          rad_sum;
   logic [ZETA_W-1:0]         zmag;
   zeta_type                  zeta4_ff, zeta4_in;

   // Stage 1: offset removal and wrap of the half angle into one turn.
   assign h0 = HANG_W'(in_beat.turn_degrees);
   always_comb begin
      priority if (h0 > HALF_TURN) begin
         h1_in = h0 - FULL_TURN;
      end else if (h0 < -HALF_TURN) begin
         h1_in = h0 + FULL_TURN;
      end else begin
         h1_in = h0;
      end
   end
   assign geom1_in.v_x = VEC_W'(in_beat.point_x) - VEC_W'(in_beat.offset_x);
   assign geom1_in.v_y = VEC_W'(in_beat.point_y) - VEC_W'(in_beat.offset_y);
   assign geom1_in.v_z = VEC_W'(in_beat.point_z) - VEC_W'(in_beat.offset_z);
   assign geom1_in.o_x = in_beat.offset_x;
   assign geom1_in.o_y = in_beat.offset_y;
   assign geom1_in.o_z = in_beat.offset_z;
   assign geom1_in.a_x = in_beat.axis_x;
   assign geom1_in.a_y = in_beat.axis_y;
   assign geom1_in.a_z = in_beat.axis_z;

   // Stage 2: fold into a quarter turn and take the magnitude.
   always_comb begin
      priority if (h1_ff > QUARTER_TURN) begin
         hf = h1_ff - HALF_TURN;
         flip2_in = 1'b1;
      end else if (h1_ff < -QUARTER_TURN) begin
         hf = h1_ff + HALF_TURN;
         flip2_in = 1'b1;
      end else begin
         hf = h1_ff;
         flip2_in = 1'b0;
      end
   end
   assign neg2_in = hf[HANG_W-1];
   assign mag2_in = neg2_in ? HMAG_W'(-hf) : HMAG_W'(hf);

   // Stage 3: the two partial products of the degree-to-radian scale.
   assign phi3_in = mag2_ff * K_HI;
   assign plo3_in = mag2_ff * K_LO;

   // Stage 4: combine, scale to Q40 and restore the sign.
   assign rad_sum = {phi3_ff, KSPLIT'(0)} + RAD_W'(plo3_ff);
   assign zmag = ZETA_W'(rad_sum >> RAD_SHIFT);
   assign zeta4_in = neg3_ff ? zeta_type'(~zmag + 1'b1) : zeta_type'(zmag);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         h1_ff    <= h1_in;
         geom1_ff <= geom1_in;
         flip2_ff <= flip2_in;
         neg2_ff  <= neg2_in;
         mag2_ff  <= mag2_in;
         geom2_ff <= geom1_ff;
         phi3_ff  <= phi3_in;
         plo3_ff  <= plo3_in;
         flip3_ff <= flip2_ff;
         neg3_ff  <= neg2_ff;
         geom3_ff <= geom2_ff;
         zeta4_ff <= zeta4_in;
         flip4_ff <= flip3_ff;
         geom4_ff <= geom3_ff;
      end
   end

   assign out_stage.valid = valid4_ff;
   assign out_stage.flip  = flip4_ff;
   assign out_stage.zeta  = zeta4_ff;
   assign out_stage.geom  = geom4_ff;
endmodule

@@ design/pra_cordic.sv @@
`timescale 1ns / 1ps
module pra_cordic (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  pra_pkg::ang_stage_type in_stage,
   output pra_pkg::trig_stage_type out_stage
);
   import pra_pkg::*;

   logic     valid_ff [CORDIC_STEPS];
   logic     flip_ff  [CORDIC_STEPS];
   trig_type x_ff     [CORDIC_STEPS];
   trig_type y_ff     [CORDIC_STEPS];
   zeta_type z_ff     [CORDIC_STEPS];
   geom_type geom_ff  [CORDIC_STEPS];

   // One micro-rotation per register stage.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam zeta_type ATAN = atan_q40(i);
      logic     valid_prev, flip_prev, up;
      trig_type x_prev, y_prev, x_in, y_in;
      zeta_type z_prev, z_in;
      geom_type geom_prev;

      if (i == 0) begin : g_first
         assign valid_prev = in_stage.valid;
         assign flip_prev  = in_stage.flip;
         assign x_prev     = CORDIC_X0;
         assign y_prev     = '0;
         assign z_prev     = in_stage.zeta;
         assign geom_prev  = in_stage.geom;
      end else begin : g_next
         assign valid_prev = valid_ff[i-1];
         assign flip_prev  = flip_ff[i-1];
         assign x_prev     = x_ff[i-1];
         assign y_prev     = y_ff[i-1];
         assign z_prev     = z_ff[i-1];
         assign geom_prev  = geom_ff[i-1];
      end

      // Rotate toward zero residual angle.
      assign up   = ~z_prev[ZETA_W-1];
      assign x_in = up ? x_prev - (y_prev >>> i) : x_prev + (y_prev >>> i);
      assign y_in = up ? y_prev + (x_prev >>> i) : y_prev - (x_prev >>> i);
      assign z_in = up ? z_prev - ATAN : z_prev + ATAN;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (enable) begin
            valid_ff[i] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            flip_ff[i] <= flip_prev;
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            geom_ff[i] <= geom_prev;
         end
      end
   end

   assign out_stage.valid = valid_ff[CORDIC_STEPS-1];
   assign out_stage.flip  = flip_ff[CORDIC_STEPS-1];
   assign out_stage.cos_v = x_ff[CORDIC_STEPS-1];
   assign out_stage.sin_v = y_ff[CORDIC_STEPS-1];
   assign out_stage.geom  = geom_ff[CORDIC_STEPS-1];
endmodule

@@ design/pra_quat.sv @@
`timescale 1ns / 1ps
module pra_quat (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  pra_pkg::trig_stage_type in_stage,
   output pra_pkg::rsp_beat_type   out_beat
);
   import pra_pkg::*;

   localparam logic signed [ROT_W:0] SAT_HI = (ROT_W+1)'({1'b0, {(COORD_W-1){1'b1}}});
   localparam logic signed [ROT_W:0] SAT_LO = -SAT_HI - 1'b1;

   function automatic coord_type sat_coord(input logic signed [ROT_W:0] val);
      priority if (val > SAT_HI) begin
         return coord_type'(SAT_HI[COORD_W-1:0]);
      end else if (val < SAT_LO) begin
         return coord_type'(SAT_LO[COORD_W-1:0]);
      end else begin
         return coord_type'(val[COORD_W-1:0]);
      end
   endfunction

   logic      valid1_ff, valid2_ff, valid3_ff, valid4_ff, valid5_ff;
   trig_type  c_in, s_cur;
   trig_type  c1_ff, q0_1_ff, q1_1_ff, q2_1_ff;
   trig_type  q0_in, q1_in, q2_in;
   vec_type   v0_1_ff, v1_1_ff, v2_1_ff;
   coord_type o0_1_ff, o1_1_ff, o2_1_ff;
   trig_type  c2_ff, q0_2_ff, q1_2_ff, q2_2_ff;
   coord_type o0_2_ff, o1_2_ff, o2_2_ff;
   prod_type  qv0_ff, qv1_ff, qv2_ff, cv0_ff, cv1_ff, cv2_ff;
   prod_type  q1v2_ff, q2v1_ff, q0v2_ff, q2v0_ff, q0v1_ff, q1v0_ff;
   trig_type  c3_ff, q0_3_ff, q1_3_ff, q2_3_ff;
   coord_type o0_3_ff, o1_3_ff, o2_3_ff;
   sum_type   tq_ff, tx_ff, ty_ff, tz_ff, tq_in, tx_in, ty_in, tz_in;
   coord_type o0_4_ff, o1_4_ff, o2_4_ff;
   acc_type   tq_q0_ff, tq_q1_ff, tq_q2_ff, tx_c_ff, tx_q1_ff, tx_q2_ff;
   acc_type   ty_c_ff, ty_q0_ff, ty_q2_ff, tz_c_ff, tz_q0_ff, tz_q1_ff;
   acc_type   r0, r1, r2;
   coord_type rx_ff, ry_ff, rz_ff;

   // Stage 1: undo the quarter-turn fold and form the vector part of q.
   assign c_in  = in_stage.flip ? -in_stage.cos_v : in_stage.cos_v;
   assign s_cur = in_stage.flip ? -in_stage.sin_v : in_stage.sin_v;
   assign q0_in = TRIG_W'(mul_q30_narrow(s_cur, TRIG_W'(in_stage.geom.a_x)));
   assign q1_in = TRIG_W'(mul_q30_narrow(s_cur, TRIG_W'(in_stage.geom.a_y)));
   assign q2_in = TRIG_W'(mul_q30_narrow(s_cur, TRIG_W'(in_stage.geom.a_z)));

   // Stage 3: the four components of q*v.
   assign tq_in = -(SUM_W'(qv0_ff) + SUM_W'(qv1_ff) + SUM_W'(qv2_ff));
   assign tx_in = SUM_W'(cv0_ff) + SUM_W'(q1v2_ff) - SUM_W'(q2v1_ff);
   assign ty_in = SUM_W'(cv1_ff) - SUM_W'(q0v2_ff) + SUM_W'(q2v0_ff);
   assign tz_in = SUM_W'(cv2_ff) + SUM_W'(q0v1_ff) - SUM_W'(q1v0_ff);

   // Stage 5: vector part of (q*v)*q^-1, offset back, saturate.
   assign r0 = -tq_q0_ff + tx_c_ff - ty_q2_ff + tz_q1_ff;
   assign r1 = -tq_q1_ff + tx_q2_ff + ty_c_ff - tz_q0_ff;
   assign r2 = -tq_q2_ff - tx_q1_ff + ty_q0_ff + tz_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
         valid5_ff <= 1'b0;
      end else if (enable) begin
         valid1_ff <= in_stage.valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
         valid5_ff <= valid4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         // Stage 1.
         c1_ff   <= c_in;
         q0_1_ff <= q0_in;
         q1_1_ff <= q1_in;
         q2_1_ff <= q2_in;
         v0_1_ff <= in_stage.geom.v_x;
         v1_1_ff <= in_stage.geom.v_y;
         v2_1_ff <= in_stage.geom.v_z;
         o0_1_ff <= in_stage.geom.o_x;
         o1_1_ff <= in_stage.geom.o_y;
         o2_1_ff <= in_stage.geom.o_z;
         // Stage 2: first-level products.
         qv0_ff  <= mul_q30_narrow(q0_1_ff, TRIG_W'(v0_1_ff));
         qv1_ff  <= mul_q30_narrow(q1_1_ff, TRIG_W'(v1_1_ff));
         qv2_ff  <= mul_q30_narrow(q2_1_ff, TRIG_W'(v2_1_ff));
         cv0_ff  <= mul_q30_narrow(c1_ff, TRIG_W'(v0_1_ff));
         cv1_ff  <= mul_q30_narrow(c1_ff, TRIG_W'(v1_1_ff));
         cv2_ff  <= mul_q30_narrow(c1_ff, TRIG_W'(v2_1_ff));
         q1v2_ff <= mul_q30_narrow(q1_1_ff, TRIG_W'(v2_1_ff));
         q2v1_ff <= mul_q30_narrow(q2_1_ff, TRIG_W'(v1_1_ff));
         q0v2_ff <= mul_q30_narrow(q0_1_ff, TRIG_W'(v2_1_ff));
         q2v0_ff <= mul_q30_narrow(q2_1_ff, TRIG_W'(v0_1_ff));
         q0v1_ff <= mul_q30_narrow(q0_1_ff, TRIG_W'(v1_1_ff));
         q1v0_ff <= mul_q30_narrow(q1_1_ff, TRIG_W'(v0_1_ff));
         c2_ff   <= c1_ff;
         q0_2_ff <= q0_1_ff;
         q1_2_ff <= q1_1_ff;
         q2_2_ff <= q2_1_ff;
         o0_2_ff <= o0_1_ff;
         o1_2_ff <= o1_1_ff;
         o2_2_ff <= o2_1_ff;
         // Stage 3.
         tq_ff   <= tq_in;
         tx_ff   <= tx_in;
         ty_ff   <= ty_in;
         tz_ff   <= tz_in;
         c3_ff   <= c2_ff;
         q0_3_ff <= q0_2_ff;
         q1_3_ff <= q1_2_ff;
         q2_3_ff <= q2_2_ff;
         o0_3_ff <= o0_2_ff;
         o1_3_ff <= o1_2_ff;
         o2_3_ff <= o2_2_ff;
         // Stage 4: second-level products against the conjugate.
         tq_q0_ff <= mul_q30_wide(tq_ff, q0_3_ff);
         tq_q1_ff <= mul_q30_wide(tq_ff, q1_3_ff);
         tq_q2_ff <= mul_q30_wide(tq_ff, q2_3_ff);
         tx_c_ff  <= mul_q30_wide(tx_ff, c3_ff);
         tx_q1_ff <= mul_q30_wide(tx_ff, q1_3_ff);
         tx_q2_ff <= mul_q30_wide(tx_ff, q2_3_ff);
         ty_c_ff  <= mul_q30_wide(ty_ff, c3_ff);
         ty_q0_ff <= mul_q30_wide(ty_ff, q0_3_ff);
         ty_q2_ff <= mul_q30_wide(ty_ff, q2_3_ff);
         tz_c_ff  <= mul_q30_wide(tz_ff, c3_ff);
         tz_q0_ff <= mul_q30_wide(tz_ff, q0_3_ff);
         tz_q1_ff <= mul_q30_wide(tz_ff, q1_3_ff);
         o0_4_ff  <= o0_3_ff;
         o1_4_ff  <= o1_3_ff;
         o2_4_ff  <= o2_3_ff;
         // Stage 5.
         rx_ff <= sat_coord((ROT_W+1)'(r0) + (ROT_W+1)'(o0_4_ff));
         ry_ff <= sat_coord((ROT_W+1)'(r1) + (ROT_W+1)'(o1_4_ff));
         rz_ff <= sat_coord((ROT_W+1)'(r2) + (ROT_W+1)'(o2_4_ff));
      end
   end

   assign out_beat.valid     = valid5_ff;
   assign out_beat.rotated_x = rx_ff;
   assign out_beat.rotated_y = ry_ff;
   assign out_beat.rotated_z = rz_ff;
endmodule

@@ tb/tb_point_rotate_about_axis.sv @@
`timescale 1ns / 1ps
module tb_point_rotate_about_axis;
   import pra_pkg::*;

   localparam int STEPS = CORDIC_STEPS;
   localparam int NUM_RANDOM = 450;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [63:0] PI_Q60_TB = 64'h3243F6A8885A308D;

   logic clock;
   logic reset;
   pra_req_if req_chan ();
   pra_rsp_if rsp_chan ();

   point_rotate_about_axis dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } coord3_type;

   typedef struct {
      req_beat_type beat;
      logic         known;
      coord3_type   want;
   } stim_row_type;

   coord3_type rotated_queue[$];
   longint atan_q40_table[STEPS];
   int error_count;
   int cycle_count;
   int send_idle_pct;
   int recv_stall_pct;

   // Free-running clock, period 20 ns.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Signed product scaled by 2^-30, magnitude truncated toward zero.
   function automatic longint mul_trunc30(input longint a, input longint b);
      logic signed [127:0] full;
      logic [127:0] mag;
      longint res;
      full = 128'(a) * 128'(b);
      mag = full[127] ? 128'(-full) : 128'(full);
      mag = mag >> 30;
      res = longint'(mag[61:0]);
      return full[127] ? -res : res;
   endfunction

   function automatic longint sat_coord(input longint v);
      if (v > 64'sd2147483647) begin
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // Quaternion rotation of one point about the offset axis.
   function automatic coord3_type rotate_point(input req_beat_type b);
      longint p[3], o[3], a[3], v[3], q[3];
      longint h, zr, cx, cy, dx, dy, cosv, sinv, tq, tx, ty, tz, r[3];
      logic [63:0] k_deg;
      bit flip;
      coord3_type res;
      p[0] = b.point_x;  p[1] = b.point_y;  p[2] = b.point_z;
      o[0] = b.offset_x; o[1] = b.offset_y; o[2] = b.offset_z;
      a[0] = b.axis_x;   a[1] = b.axis_y;   a[2] = b.axis_z;
      for (int i = 0; i < 3; i++) v[i] = p[i] - o[i];
      // The angle field read as Q.17 degrees is the half angle.
      h = longint'(b.turn_degrees);
      flip = 1'b0;
      if (h > (64'sd180 <<< 17)) h -= (64'sd360 <<< 17);
      if (h < -(64'sd180 <<< 17)) h += (64'sd360 <<< 17);
      if (h > (64'sd90 <<< 17)) begin
         h -= (64'sd180 <<< 17);
         flip = 1'b1;
      end
      if (h < -(64'sd90 <<< 17)) begin
         h += (64'sd180 <<< 17);
         flip = 1'b1;
      end
      k_deg = PI_Q60_TB / 64'd180;
      begin
         logic [127:0] m;
         m = 128'(h < 0 ? -h : h) * 128'(k_deg);
         zr = longint'(m >> 37);
         if (h < 0) zr = -zr;
      end
      // CORDIC in rotation mode.
      cx = 64'h26DD3B6A;
      cy = 0;
      for (int i = 0; i < STEPS; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (zr >= 0) begin
            cx -= dx; cy += dy; zr -= atan_q40_table[i];
         end else begin
            cx += dx; cy -= dy; zr += atan_q40_table[i];
         end
      end
      cosv = flip ? -cx : cx;
      sinv = flip ? -cy : cy;
      for (int i = 0; i < 3; i++) q[i] = mul_trunc30(sinv, a[i]);
      tq = -(mul_trunc30(q[0], v[0]) + mul_trunc30(q[1], v[1]) + mul_trunc30(q[2], v[2]));
      tx = mul_trunc30(cosv, v[0]) + mul_trunc30(q[1], v[2]) - mul_trunc30(q[2], v[1]);
      ty = mul_trunc30(cosv, v[1]) - mul_trunc30(q[0], v[2]) + mul_trunc30(q[2], v[0]);
      tz = mul_trunc30(cosv, v[2]) + mul_trunc30(q[0], v[1]) - mul_trunc30(q[1], v[0]);
      r[0] = -mul_trunc30(tq, q[0]) + mul_trunc30(tx, cosv)
             - mul_trunc30(ty, q[2]) + mul_trunc30(tz, q[1]);
      r[1] = -mul_trunc30(tq, q[1]) + mul_trunc30(tx, q[2])
             + mul_trunc30(ty, cosv) - mul_trunc30(tz, q[0]);
      r[2] = -mul_trunc30(tq, q[2]) - mul_trunc30(tx, q[1])
             + mul_trunc30(ty, q[0]) + mul_trunc30(tz, cosv);
      res.x = 32'(sat_coord(r[0] + o[0]));
      res.y = 32'(sat_coord(r[1] + o[1]));
      res.z = 32'(sat_coord(r[2] + o[2]));
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
         2: return $urandom_range(0, 1) ? 32'h7FFFFFFF - $urandom_range(0, 1000)
                                          : 32'h80000000 + $urandom_range(0, 1000);
         default: return 32'($signed($urandom_range(0, 200000)) - 100000);
      endcase
   endfunction

   function automatic logic signed [31:0] rand_axis();
      if ($urandom_range(0, 3) == 0) begin
         return $urandom_range(0, 1) ? 32'sh40000000 : -32'sh40000000;
      end
      return 32'($signed($urandom_range(0, 32'h80000000)) - 32'sh40000000);
   endfunction

   function automatic req_beat_type rand_beat();
      req_beat_type b;
      b.point_x = rand_coord();  b.point_y = rand_coord();  b.point_z = rand_coord();
      b.offset_x = rand_coord(); b.offset_y = rand_coord(); b.offset_z = rand_coord();
      b.axis_x = rand_axis();    b.axis_y = rand_axis();    b.axis_z = rand_axis();
      b.turn_degrees = 26'($signed($urandom_range(0, 47185920)) - 23592960);
      return b;
   endfunction

   function automatic req_beat_type make_beat(input logic signed [31:0] px, py, pz,
                                              ox, oy, oz, ax, ay, az,
                                              input logic signed [25:0] deg);
      req_beat_type b;
      b.point_x = px;  b.point_y = py;  b.point_z = pz;
      b.offset_x = ox; b.offset_y = oy; b.offset_z = oz;
      b.axis_x = ax;   b.axis_y = ay;   b.axis_z = az;
      b.turn_degrees = deg;
      return b;
   endfunction

   // Offer one beat and hold it until accepted.
   task automatic send_beat(input req_beat_type b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.point_x <= b.point_x;   req_chan.point_y <= b.point_y;
      req_chan.point_z <= b.point_z;   req_chan.offset_x <= b.offset_x;
      req_chan.offset_y <= b.offset_y; req_chan.offset_z <= b.offset_z;
      req_chan.axis_x <= b.axis_x;     req_chan.axis_y <= b.axis_y;
      req_chan.axis_z <= b.axis_z;     req_chan.turn_degrees <= b.turn_degrees;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Expected results are queued at acceptance by the monitor below.
   req_beat_type pending_beats[$];
   coord3_type known_results[$];
   logic known_flags[$];

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         rotated_queue.push_back(rotate_point(pending_beats.pop_front()));
      end
   end

   // Compare each result beat with the oldest expectation.
   always @(posedge clock) begin
      coord3_type want;
      logic known;
      coord3_type fixed;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (rotated_queue.size() == 0) begin
            report_mismatch("unexpected result beat", rsp_chan.rotated_x, 0);
         end else begin
            want = rotated_queue.pop_front();
            known = known_flags.pop_front();
            fixed = known_results.pop_front();
            if (known) begin
               if (fixed.x !== want.x) report_mismatch("table rotated_x", fixed.x, want.x);
               if (fixed.y !== want.y) report_mismatch("table rotated_y", fixed.y, want.y);
               if (fixed.z !== want.z) report_mismatch("table rotated_z", fixed.z, want.z);
            end
            if (rsp_chan.rotated_x !== want.x)
               report_mismatch("rotated_x", rsp_chan.rotated_x, want.x);
            if (rsp_chan.rotated_y !== want.y)
               report_mismatch("rotated_y", rsp_chan.rotated_y, want.y);
            if (rsp_chan.rotated_z !== want.z)
               report_mismatch("rotated_z", rsp_chan.rotated_z, want.z);
         end
      end
   end

   // Receiver back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic queue_and_send(input req_beat_type b, input logic known,
                                 input coord3_type fixed);
      pending_beats.push_back(b);
      known_flags.push_back(known);
      known_results.push_back(fixed);
      send_beat(b);
   endtask

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      coord3_type none;
      logic signed [31:0] mx, mn, one_ax;
      mx = 32'sh7FFFFFFF;
      mn = 32'sh80000000;
      one_ax = 32'sh40000000;
      none = '{0, 0, 0};
      error_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.point_x = '0;  req_chan.point_y = '0;  req_chan.point_z = '0;
      req_chan.offset_x = '0; req_chan.offset_y = '0; req_chan.offset_z = '0;
      req_chan.axis_x = '0;   req_chan.axis_y = '0;   req_chan.axis_z = '0;
      req_chan.turn_degrees = '0;
      rsp_chan.ready = 1'b1;

      // Arctangent table in Q40 from the truncated series in Q60.
      atan_q40_table[0] = longint'(PI_Q60_TB >> 22);
      for (int i = 1; i < STEPS; i++) begin
         longint acc;
         acc = 0;
         for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
            longint term;
            term = longint'((64'd1 << (60 - i * (2 * k + 1))) / 64'(2 * k + 1));
            acc = (k % 2 == 1) ? acc - term : acc + term;
         end
         atan_q40_table[i] = acc >>> 20;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table; a zero angle or a point on the offset gives the point back.
      row = '{make_beat(0, 0, 0, 0, 0, 0, one_ax, 0, 0, 0), 1'b1, '{0, 0, 0}};
      rows.push_back(row);
      row = '{make_beat(mx, mn, 12345, mx, mn, 12345, 0, one_ax, 0, 26'sd11796480),
              1'b1, '{mx, mn, 12345}};
      rows.push_back(row);
      row = '{make_beat(65536, 0, 0, 0, 0, 0, 0, 0, one_ax, 26'sd5898240), 1'b0, none};
      rows.push_back(row);
      row = '{make_beat(65536, 65536, 65536, 0, 0, 0, 0, 0, -one_ax, 26'sd11796480),
              1'b0, none};
      rows.push_back(row);
      row = '{make_beat(mx, mx, mx, mn, mn, mn, one_ax, one_ax, one_ax, 26'sd23592960),
              1'b0, none};
      rows.push_back(row);
      row = '{make_beat(mn, mn, mn, mx, mx, mx, -one_ax, -one_ax, -one_ax, -26'sd23592960),
              1'b0, none};
      rows.push_back(row);
      row = '{make_beat(mx, 0, mn, 0, 0, 0, one_ax, 0, 0, 26'sh1FFFFFF), 1'b0, none};
      rows.push_back(row);
      row = '{make_beat(-1, 1, -1, 1, -1, 1, 0, one_ax, 0, 26'sh2000000), 1'b0, none};
      rows.push_back(row);
      row = '{make_beat(1000000, -2000000, 3000000, 0, 0, 0, one_ax, 0, 0, -26'sd5898240),
              1'b0, none};
      rows.push_back(row);
      row = '{make_beat(1000000, 0, 0, 0, 0, 0, 0, 0, one_ax, 26'sd17694720), 1'b0, none};
      rows.push_back(row);
      row = '{make_beat(1000000, 2000000, 0, 0, 0, 0, 0, 0, one_ax, -26'sd17694720),
              1'b0, none};
      rows.push_back(row);
      row = '{make_beat(1 << 20, 0, 0, 0, 0, 0, one_ax, one_ax, 0, 26'sd5898240), 1'b0, none};
      rows.push_back(row);
      row = '{make_beat(mx, mx, 0, -mx, 0, 0, 0, 0, one_ax, 26'sd11796480), 1'b0, none};
      rows.push_back(row);
      row = '{make_beat(-32'sd5, 32'sd7, 32'sd3, 0, 0, 0, 0, one_ax, 0, 26'sd1), 1'b0, none};
      rows.push_back(row);
      foreach (rows[i]) queue_and_send(rows[i].beat, rows[i].known, rows[i].want);

      // Random part over four idling phases.
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 64 : 35) : 0;
         recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 64 : 35) : 0;
         for (int n = 0; n < NUM_RANDOM / 4; n++) queue_and_send(rand_beat(), 1'b0, none);
      end
      req_chan.valid <= 1'b0;

      while (rotated_queue.size() != 0 || pending_beats.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
